// ----- src/tvpl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tvpl_pkg;

    // Field and register widths
    localparam int POS_W    = 16;
    localparam int VEL_W    = 16;
    localparam int TGT_W    = 15;
    localparam int CMD_W    = 16;
    localparam int DUTY_W   = 16;
    localparam int KP_W     = 8;
    localparam int ACCEL_W  = 12;
    localparam int PMAX_W   = 15;
    localparam int PLAT_W   = 16;
    localparam int PWM_W    = 16;
    localparam int TPS_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register index codes
    localparam logic [CFG_IDX_W-1:0] REG_KP            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLATEAU_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC = 3'd5;

    // Register reset values
    localparam logic [KP_W-1:0]    KP_RESET    = 8'd4;
    localparam logic [ACCEL_W-1:0] ACCEL_RESET = 12'd100;
    localparam logic [PMAX_W-1:0]  PMAX_RESET  = 15'd4000;
    localparam logic [PLAT_W-1:0]  PLAT_RESET  = 16'd300;
    localparam logic [PWM_W-1:0]   PWM_RESET   = 16'd500;
    localparam logic [TPS_W-1:0]   TPS_RESET   = 10'd50;

    // Gain scaling: command step is kp * error / 2^GAIN_SHIFT
    localparam int GAIN_SHIFT = 8;

endpackage

`default_nettype wire

// ----- src/trapezoid_velocity_p_loop.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Trapezoidal velocity profile generator with an incremental P velocity loop.
// Input channel (in_valid/in_ready): one request per control tick carrying the
// raw quadrature position_count. Output channel (out_valid/out_ready): one
// result per request with the profile target, measured velocity, saturated
// motor command and the forward/reverse PWM duties.
// Throughput: one request per cycle unless the receiver stalls. Stage 1 holds
// the velocity product (count difference times tick rate); stage 2 runs the
// profile ramp, the gain multiply, the command accumulate and the duty split
// into the result register.
// The two multipliers sit in separate stages: stage 1 plus the result register.
// When the receiver stalls, the result holds; a request still enters stage 1,
// after which in_ready drops until the result is taken.
// Reset (rst_n low, asynchronous) empties the pipeline, zeroes the profile and
// command state and the previous position, and loads the register defaults.
// The user must write configuration (cfg_we/cfg_index/cfg_data) only while idle;
// the block does not enforce this. Indexes beyond the register list are ignored.

module trapezoid_velocity_p_loop (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [tvpl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tvpl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [tvpl_pkg::POS_W-1:0]        position_count,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [tvpl_pkg::TGT_W-1:0]             vel_target,
    output logic signed [tvpl_pkg::VEL_W-1:0]      vel_measured,
    output logic signed [tvpl_pkg::CMD_W-1:0]      motor_command,
    output logic [tvpl_pkg::DUTY_W-1:0]            duty_forward,
    output logic [tvpl_pkg::DUTY_W-1:0]            duty_reverse
);

    localparam int ERR_W  = 18;                 // target - measured, exact
    localparam int PROD_W = ERR_W + tvpl_pkg::KP_W + 1;
    localparam int DLT_W  = PROD_W - tvpl_pkg::GAIN_SHIFT;
    localparam int SUM_W  = DLT_W + 1;
    localparam int RAMP_W = 17;                 // target +/- step, signed
    localparam int MUL1_W = tvpl_pkg::POS_W + tvpl_pkg::TPS_W;

    // ---------------- configuration registers ----------------
    logic [tvpl_pkg::KP_W-1:0]    kp_reg;
    logic [tvpl_pkg::ACCEL_W-1:0] accel_reg;
    logic [tvpl_pkg::PMAX_W-1:0]  pmax_reg;
    logic [tvpl_pkg::PLAT_W-1:0]  plat_reg;
    logic [tvpl_pkg::PWM_W-1:0]   pwm_reg;
    logic [tvpl_pkg::TPS_W-1:0]   tps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= tvpl_pkg::KP_RESET;
            accel_reg <= tvpl_pkg::ACCEL_RESET;
            pmax_reg  <= tvpl_pkg::PMAX_RESET;
            plat_reg  <= tvpl_pkg::PLAT_RESET;
            pwm_reg   <= tvpl_pkg::PWM_RESET;
            tps_reg   <= tvpl_pkg::TPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tvpl_pkg::REG_KP:            kp_reg    <= cfg_data[tvpl_pkg::KP_W-1:0];
                tvpl_pkg::REG_ACCEL_STEP:    accel_reg <= cfg_data[tvpl_pkg::ACCEL_W-1:0];
                tvpl_pkg::REG_PROFILE_MAX:   pmax_reg  <= cfg_data[tvpl_pkg::PMAX_W-1:0];
                tvpl_pkg::REG_PLATEAU_TICKS: plat_reg  <= cfg_data[tvpl_pkg::PLAT_W-1:0];
                tvpl_pkg::REG_PWM_PERIOD:    pwm_reg   <= cfg_data[tvpl_pkg::PWM_W-1:0];
                tvpl_pkg::REG_TICKS_PER_SEC: tps_reg   <= cfg_data[tvpl_pkg::TPS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic in_fire;
    logic s2_load;

    assign s2_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;
            if (s2_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------- stage 1: measured velocity ----------------
    logic [tvpl_pkg::POS_W-1:0] prev_pos_reg;
    logic [tvpl_pkg::POS_W-1:0] pos_diff;
    logic [MUL1_W-1:0]          vel_prod;
    logic [tvpl_pkg::VEL_W-1:0] vel_s1_reg;

    assign pos_diff = position_count - prev_pos_reg;   // wraps mod 2^16
    assign vel_prod = {{tvpl_pkg::TPS_W{1'b0}}, pos_diff}
                    * {{tvpl_pkg::POS_W{1'b0}}, tps_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_pos_reg <= '0;
        else if (in_fire)
            prev_pos_reg <= position_count;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            vel_s1_reg <= vel_prod[tvpl_pkg::VEL_W-1:0];
    end

    // ---------------- stage 2: profile, P loop, duty split ----------------
    logic [tvpl_pkg::TGT_W-1:0]  target_reg, target_next;
    logic                        ramp_down_reg, ramp_down_next;
    logic                        plat_seen_reg, plat_seen_next;
    logic [tvpl_pkg::PLAT_W-1:0] plat_cnt_reg, plat_cnt_next;
    logic [tvpl_pkg::CMD_W-1:0]  cmd_reg, cmd_next;

    logic [RAMP_W-1:0]           ramp_sum;
    logic                        above_max;
    logic [ERR_W-1:0]            err;
    logic [PROD_W-1:0]           prod;
    logic [PROD_W-1:0]           prod_adj;
    logic [DLT_W-1:0]            delta;
    logic [SUM_W-1:0]            cmd_sum;
    logic [tvpl_pkg::CMD_W:0]    cmd_mag;
    logic [tvpl_pkg::PWM_W:0]    duty_cl;
    logic [tvpl_pkg::DUTY_W-1:0] fwd_next, rev_next;

    always_comb
    begin
        // Ramp the target one step in the current direction
        if (ramp_down_reg)
            ramp_sum = {2'b00, target_reg} - {5'd0, accel_reg};
        else
            ramp_sum = {2'b00, target_reg} + {5'd0, accel_reg};

        above_max = !ramp_sum[RAMP_W-1] && (ramp_sum[RAMP_W-2:0] > {1'b0, pmax_reg});

        plat_seen_next = plat_seen_reg;
        plat_cnt_next  = plat_cnt_reg;
        ramp_down_next = ramp_down_reg;
        if (above_max)
        begin
            // first tick over the plateau only marks it; later ticks count
            plat_seen_next = 1'b1;
            if (plat_seen_reg)
                plat_cnt_next = plat_cnt_reg + 1'b1;
            if (plat_cnt_next == plat_reg)
                ramp_down_next = !ramp_down_reg;
            target_next = pmax_reg;
        end
        else if (ramp_sum[RAMP_W-1])
            target_next = '0;
        else
            target_next = ramp_sum[tvpl_pkg::TGT_W-1:0];

        // Velocity error, kept exact in 18 bits signed
        err = {3'b000, target_next} - {{2{vel_s1_reg[tvpl_pkg::VEL_W-1]}}, vel_s1_reg};

        // kp * err, kp zero extended and err sign extended give an exact signed product
        prod = {{(PROD_W - tvpl_pkg::KP_W){1'b0}}, kp_reg}
             * {{(PROD_W - ERR_W){err[ERR_W-1]}}, err};

        // Divide by 256 rounding toward zero
        prod_adj = prod + (prod[PROD_W-1] ? PROD_W'(255) : '0);
        delta    = prod_adj[PROD_W-1:tvpl_pkg::GAIN_SHIFT];

        cmd_sum = {{(SUM_W - tvpl_pkg::CMD_W){cmd_reg[tvpl_pkg::CMD_W-1]}}, cmd_reg}
                + {delta[DLT_W-1], delta};

        // Saturate to 16 bits signed
        if (cmd_sum[SUM_W-1:tvpl_pkg::CMD_W-1] == '0
            || cmd_sum[SUM_W-1:tvpl_pkg::CMD_W-1] == '1)
            cmd_next = cmd_sum[tvpl_pkg::CMD_W-1:0];
        else if (cmd_sum[SUM_W-1])
            cmd_next = {1'b1, {(tvpl_pkg::CMD_W-1){1'b0}}};
        else
            cmd_next = {1'b0, {(tvpl_pkg::CMD_W-1){1'b1}}};

        // Duty split: magnitude clamped to the PWM period
        if (cmd_next[tvpl_pkg::CMD_W-1])
            cmd_mag = '0 - {1'b1, cmd_next};
        else
            cmd_mag = {1'b0, cmd_next};

        if (cmd_mag < {1'b0, pwm_reg})
            duty_cl = cmd_mag;
        else
            duty_cl = {1'b0, pwm_reg};

        if (cmd_next[tvpl_pkg::CMD_W-1])
        begin
            fwd_next = '0;
            rev_next = duty_cl[tvpl_pkg::DUTY_W-1:0];
        end
        else
        begin
            fwd_next = duty_cl[tvpl_pkg::DUTY_W-1:0];
            rev_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            ramp_down_reg <= 1'b0;
            plat_seen_reg <= 1'b0;
            plat_cnt_reg  <= '0;
            cmd_reg       <= '0;
        end
        else if (s2_load)
        begin
            target_reg    <= target_next;
            ramp_down_reg <= ramp_down_next;
            plat_seen_reg <= plat_seen_next;
            plat_cnt_reg  <= plat_cnt_next;
            cmd_reg       <= cmd_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            vel_target    <= target_next;
            vel_measured  <= vel_s1_reg;
            motor_command <= cmd_next;
            duty_forward  <= fwd_next;
            duty_reverse  <= rev_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/tvpl_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tvpl_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [tvpl_pkg::TGT_W-1:0]        vel_target,
    input wire logic signed [tvpl_pkg::VEL_W-1:0] vel_measured,
    input wire logic signed [tvpl_pkg::CMD_W-1:0] motor_command,
    input wire logic [tvpl_pkg::DUTY_W-1:0]       duty_forward,
    input wire logic [tvpl_pkg::DUTY_W-1:0]       duty_reverse
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(motor_command)
            && $stable(vel_target) && $stable(vel_measured))
        else $error("stalled result changed");

    a_neg_no_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motor_command[tvpl_pkg::CMD_W-1] |-> duty_forward == '0)
        else $error("forward duty with negative command");

    a_pos_no_rev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !motor_command[tvpl_pkg::CMD_W-1] |-> duty_reverse == '0)
        else $error("reverse duty with non-negative command");

    a_fwd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !motor_command[tvpl_pkg::CMD_W-1]
            |-> duty_forward <= motor_command[tvpl_pkg::CMD_W-1:0])
        else $error("forward duty exceeds command");

endmodule

bind trapezoid_velocity_p_loop tvpl_checker u_tvpl_checker (.*);

`default_nettype wire

// ----- sim/trapezoid_velocity_p_loop_tb.sv -----
`timescale 1ns / 1ps

module trapezoid_velocity_p_loop_tb;

    localparam int RANDOM_TICKS = 1400;

    // One expected result per tick request
    typedef struct packed {
        logic [tvpl_pkg::TGT_W-1:0]        tgt;
        logic signed [tvpl_pkg::VEL_W-1:0] vel;
        logic signed [tvpl_pkg::CMD_W-1:0] cmd;
        logic [tvpl_pkg::DUTY_W-1:0]       fwd;
        logic [tvpl_pkg::DUTY_W-1:0]       rev;
    } tick_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [tvpl_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [tvpl_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic [tvpl_pkg::POS_W-1:0]        position_count;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [tvpl_pkg::TGT_W-1:0]        vel_target;
    logic signed [tvpl_pkg::VEL_W-1:0] vel_measured;
    logic signed [tvpl_pkg::CMD_W-1:0] motor_command;
    logic [tvpl_pkg::DUTY_W-1:0]       duty_forward;
    logic [tvpl_pkg::DUTY_W-1:0]       duty_reverse;

    // Register shadows, kept masked to their widths
    int kp_q         = tvpl_pkg::KP_RESET;
    int accel_q      = tvpl_pkg::ACCEL_RESET;
    int pmax_q       = tvpl_pkg::PMAX_RESET;
    int plat_ticks_q = tvpl_pkg::PLAT_RESET;
    int pwm_q        = tvpl_pkg::PWM_RESET;
    int tps_q        = tvpl_pkg::TPS_RESET;

    // Profile and loop state of the local copy
    logic [tvpl_pkg::POS_W-1:0]  prev_pos_q  = '0;
    int                          tgt_q       = 0;
    logic                        ramp_down_q = 1'b0;
    logic                        plat_seen_q = 1'b0;
    logic [tvpl_pkg::PLAT_W-1:0] plat_cnt_q  = '0;
    int                          cmd_q       = 0;

    tick_result_t pending_ticks[$];

    int ticks_sent    = 0;
    int ticks_checked = 0;
    int fail_count    = 0;
    int cfg_writes    = 0;
    int ramp_flips    = 0;

    // Pacing knobs: sender bursts and receiver back-pressure
    bit send_idle_en = 1'b1;
    bit rcv_stall_en = 1'b1;
    int burst_left   = 0;
    int stall_left   = 0;

    trapezoid_velocity_p_loop DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .position_count (position_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .vel_target     (vel_target),
        .vel_measured   (vel_measured),
        .motor_command  (motor_command),
        .duty_forward   (duty_forward),
        .duty_reverse   (duty_reverse)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One control tick of the profile and loop. Updates the local state and
    // returns what the DUT must report for this request.
    function automatic tick_result_t step_profile(input logic [tvpl_pkg::POS_W-1:0] pos);
        logic [tvpl_pkg::POS_W-1:0] diff;
        logic [31:0]                prod;
        int                         vel;
        int                         tgt;
        int                         delta;
        int                         cmd;
        int                         mag;
        tick_result_t               r;

        // Wrapped count difference scaled by tick rate, kept to 16 bits
        diff = pos - prev_pos_q;
        prod = diff * tps_q;
        vel = $signed(prod[tvpl_pkg::VEL_W-1:0]);
        prev_pos_q = pos;

        tgt = ramp_down_q ? tgt_q - accel_q : tgt_q + accel_q;
        if (tgt > pmax_q)
        begin
            // First tick past the plateau only marks it; later ones count
            if (!plat_seen_q)
                plat_seen_q = 1'b1;
            else
                plat_cnt_q = plat_cnt_q + 1'b1;
            if (plat_cnt_q == plat_ticks_q[tvpl_pkg::PLAT_W-1:0])
            begin
                ramp_down_q = !ramp_down_q;
                ramp_flips++;
            end
            tgt = pmax_q;
        end
        if (tgt < 0)
            tgt = 0;
        tgt_q = tgt;

        // Error kept at full width; division truncates toward zero
        delta = (kp_q * (tgt - vel)) / (1 << tvpl_pkg::GAIN_SHIFT);
        cmd = cmd_q + delta;
        if (cmd > 32767)
            cmd = 32767;
        if (cmd < -32768)
            cmd = -32768;
        cmd_q = cmd;

        r.tgt = tgt[tvpl_pkg::TGT_W-1:0];
        r.vel = vel[tvpl_pkg::VEL_W-1:0];
        r.cmd = cmd[tvpl_pkg::CMD_W-1:0];
        if (cmd >= 0)
        begin
            r.fwd = (cmd < pwm_q) ? cmd[tvpl_pkg::DUTY_W-1:0] : pwm_q[tvpl_pkg::DUTY_W-1:0];
            r.rev = '0;
        end
        else
        begin
            mag = -cmd;
            r.fwd = '0;
            r.rev = (mag < pwm_q) ? mag[tvpl_pkg::DUTY_W-1:0] : pwm_q[tvpl_pkg::DUTY_W-1:0];
        end
        return r;
    endfunction

    // Mostly values from lo up to cap, with the two ends showing up now and then
    function automatic int pick_value(input int lo, input int hi, input int cap);
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return lo;
        if (roll == 1)
            return hi;
        return $urandom_range(lo, cap);
    endfunction

    // Register write; only called with the pipeline drained
    task automatic write_reg(input logic [tvpl_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[tvpl_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            tvpl_pkg::REG_KP:
                kp_q = value & ((1 << tvpl_pkg::KP_W) - 1);
            tvpl_pkg::REG_ACCEL_STEP:
                accel_q = value & ((1 << tvpl_pkg::ACCEL_W) - 1);
            tvpl_pkg::REG_PROFILE_MAX:
                pmax_q = value & ((1 << tvpl_pkg::PMAX_W) - 1);
            tvpl_pkg::REG_PLATEAU_TICKS:
                plat_ticks_q = value & ((1 << tvpl_pkg::PLAT_W) - 1);
            tvpl_pkg::REG_PWM_PERIOD:
                pwm_q = value & ((1 << tvpl_pkg::PWM_W) - 1);
            tvpl_pkg::REG_TICKS_PER_SEC:
                tps_q = value & ((1 << tvpl_pkg::TPS_W) - 1);
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Send one position request. Valid is only dropped at the start of a gap,
    // never in the step where the next request raises it.
    task automatic send_tick(input logic [tvpl_pkg::POS_W-1:0] pos);
        if (send_idle_en)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        in_valid       <= 1'b1;
        position_count <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_ticks.push_back(step_profile(pos));
        ticks_sent++;
    endtask

    // Hold off the sender until every queued result is back, then let the
    // two pipeline stages settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register defaults straight out of reset, position extremes and wrap
    task automatic test_reset_defaults();
        send_tick(16'h0000);
        send_tick(16'h0001);
        send_tick(16'hFFFF);
        send_tick(16'h8000);
        send_tick(16'h7FFF);
        send_tick(16'h0000);
    endtask

    // Zero plateau ticks: the ramp must turn on the first tick over the top.
    // Relies on the plateau not having been reached since reset.
    task automatic test_zero_plateau();
        wait_drained();
        write_reg(tvpl_pkg::REG_PLATEAU_TICKS, 0);
        write_reg(tvpl_pkg::REG_PROFILE_MAX, 650);
        send_tick(16'h0010);
        send_tick(16'h0020);
        send_tick(16'h0030);
    endtask

    // Profile max dropped under the falling target: plateau logic runs again
    // and the counter match flips the ramp back up.
    task automatic test_plateau_reentry();
        wait_drained();
        write_reg(tvpl_pkg::REG_PROFILE_MAX, 100);
        write_reg(tvpl_pkg::REG_PLATEAU_TICKS, 1);
        send_tick(16'h0040);
        send_tick(16'h0050);
        send_tick(16'h0060);
    endtask

    // Full gain and full-scale errors: positive then negative command
    // saturation, reverse duty pinned at the period, and a zero period.
    task automatic test_command_saturation();
        logic [tvpl_pkg::POS_W-1:0] pos;
        wait_drained();
        write_reg(tvpl_pkg::REG_KP, 255);
        write_reg(tvpl_pkg::REG_ACCEL_STEP, 4000);
        write_reg(tvpl_pkg::REG_PROFILE_MAX, 32767);
        write_reg(tvpl_pkg::REG_TICKS_PER_SEC, 1);
        write_reg(tvpl_pkg::REG_PWM_PERIOD, 65535);
        pos = prev_pos_q;
        // half-turn steps read back as -32768, target climbs to the top
        repeat (9)
        begin
            pos = pos + 16'h8000;
            send_tick(pos);
        end
        wait_drained();
        write_reg(tvpl_pkg::REG_PROFILE_MAX, 0);
        write_reg(tvpl_pkg::REG_PWM_PERIOD, 1);
        repeat (3)
        begin
            pos = pos + 16'h7FFF;
            send_tick(pos);
        end
        wait_drained();
        write_reg(tvpl_pkg::REG_PWM_PERIOD, 0);
        pos = pos + 16'h7FFF;
        send_tick(pos);
    endtask

    // Pick registers for the next random stretch. The profile has no way back
    // once it has ramped down to zero, so the choices keep the target off
    // the floor for the length of the stretch.
    task automatic shape_phase(input int n_items);
        int accel_new;
        int pmax_new;
        int roll;
        if ($urandom_range(0, 1))
            write_reg(tvpl_pkg::REG_KP, pick_value(0, 255, 255));
        if ($urandom_range(0, 1))
            write_reg(tvpl_pkg::REG_TICKS_PER_SEC, pick_value(1, 1000, 120));
        if ($urandom_range(0, 1))
            write_reg(tvpl_pkg::REG_PWM_PERIOD, pick_value(1, 65535, 3000));
        if (ramp_down_q)
        begin
            if (tgt_q > 0 && $urandom_range(0, 1))
            begin
                // drop the max under the next target and flip back up
                accel_new = $urandom_range(0, (tgt_q > 4000) ? 4000 : tgt_q - 1);
                pmax_new  = $urandom_range(0, tgt_q - accel_new - 1);
                write_reg(tvpl_pkg::REG_ACCEL_STEP, accel_new);
                write_reg(tvpl_pkg::REG_PROFILE_MAX, pmax_new);
                write_reg(tvpl_pkg::REG_PLATEAU_TICKS, plat_cnt_q + 1);
            end
            else
                write_reg(tvpl_pkg::REG_ACCEL_STEP, $urandom_range(0, tgt_q / (n_items + 1)));
        end
        else
        begin
            pmax_new = pick_value(1, 32767, 32767);
            write_reg(tvpl_pkg::REG_PROFILE_MAX, pmax_new);
            write_reg(tvpl_pkg::REG_ACCEL_STEP, $urandom_range(0, pmax_new / (n_items + 1)));
            roll = $urandom_range(0, 7);
            if (roll == 0)
                write_reg(tvpl_pkg::REG_PLATEAU_TICKS, 65535);
            else
                write_reg(tvpl_pkg::REG_PLATEAU_TICKS, plat_cnt_q + $urandom_range(0, 25));
        end
    endtask

    // Random stretches: mostly smooth encoder motion with a drifting speed,
    // some random counts and some large jumps.
    task automatic test_random_ticks();
        int                         n_items;
        int                         roll;
        int                         step;
        int                         speed;
        int                         done;
        logic [tvpl_pkg::POS_W-1:0] pos;
        done = 0;
        pos  = prev_pos_q;
        while (done < RANDOM_TICKS)
        begin
            n_items = $urandom_range(20, 60);
            wait_drained();
            shape_phase(n_items);
            send_idle_en = ($urandom_range(0, 3) != 0);
            rcv_stall_en = ($urandom_range(0, 3) != 0);
            speed = $urandom_range(0, 4000);
            speed = speed - 2000;
            repeat (n_items)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 85)
                begin
                    step  = $urandom_range(0, 20);
                    speed = speed + step - 10;
                    pos   = pos + speed[tvpl_pkg::POS_W-1:0];
                end
                else if (roll < 95)
                    pos = tvpl_pkg::POS_W'($urandom());
                else
                    pos = tvpl_pkg::POS_W'(pos + $urandom_range(1000, 60000));
                send_tick(pos);
                done++;
            end
        end
    endtask

    // Steep step and a low max so the profile runs down and clamps at zero
    task automatic test_ramp_to_rest();
        logic [tvpl_pkg::POS_W-1:0] pos;
        wait_drained();
        send_idle_en = 1'b1;
        rcv_stall_en = 1'b1;
        write_reg(tvpl_pkg::REG_ACCEL_STEP, 3000);
        write_reg(tvpl_pkg::REG_PROFILE_MAX, $urandom_range(0, 2000));
        // when rising, turn on the first tick over the top; when falling, stay down
        write_reg(tvpl_pkg::REG_PLATEAU_TICKS, ramp_down_q ? plat_cnt_q : plat_cnt_q + 1);
        pos = prev_pos_q;
        repeat (30)
        begin
            pos = tvpl_pkg::POS_W'(pos + $urandom_range(0, 60));
            send_tick(pos);
        end
    endtask

    // Receiver: random stalls of random length; ready solid when disabled
    always @(posedge clk)
    begin
        if (!rcv_stall_en)
            out_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_ready <= 1'b1;
    end

    // Result checker: each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_ticks.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] result with no request outstanding", $realtime);
            end
            else
            begin
                want = pending_ticks.pop_front();
                ticks_checked++;
                if (vel_target !== want.tgt || vel_measured !== want.vel ||
                    motor_command !== want.cmd || duty_forward !== want.fwd ||
                    duty_reverse !== want.rev)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $write("[%0t] mismatch (exp/got): target %0d/%0d vel %0d/%0d ",
                               $realtime, want.tgt, vel_target, want.vel, vel_measured);
                        $display("cmd %0d/%0d fwd %0d/%0d rev %0d/%0d",
                                 want.cmd, motor_command, want.fwd, duty_forward,
                                 want.rev, duty_reverse);
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("trapezoid_velocity_p_loop verification failed");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= tvpl_pkg::REG_KP;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        position_count <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_plateau();
        test_plateau_reentry();
        test_command_saturation();
        test_random_ticks();
        test_ramp_to_rest();

        wait_drained();
        $display("Covered %0d tick requests, %0d results checked, %0d register writes,",
                 ticks_sent, ticks_checked, cfg_writes);
        $display("%0d ramp reversals, %0d failures", ramp_flips, fail_count);
        if (fail_count == 0 && pending_ticks.size() == 0)
            $display("trapezoid_velocity_p_loop verification clean");
        else
            $display("trapezoid_velocity_p_loop verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tvpl_pkg.sv
src/trapezoid_velocity_p_loop.sv
src/tvpl_checker.sv
sim/trapezoid_velocity_p_loop_tb.sv
